>>> hdl/rlmds_pkg.sv
package rlmds_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_FIELD_W = 16;
    localparam int DUTY_FIELD_W  = 16;
    localparam int LUM_W         = 16;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 3;

    // Datapath widths, sized for the widest coordinate setting.
    localparam int P_W    = COORD_FIELD_W + 1;   // signed coordinate difference
    localparam int A_W    = 54;                  // multiplier operand A, signed
    localparam int B_W    = 17;                  // multiplier operand B, signed
    localparam int PROD_W = A_W + B_W;           // full product
    localparam int M_W    = 35;                  // cofactor, signed
    localparam int S_W    = 54;                  // determinant sum, signed
    localparam int T_W    = 54;                  // y times |cofactor|
    localparam int WIDE_W = 70;                  // numerator, denominator, remainder

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_RED_CHROMA     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_CHROMA   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_CHROMA    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RED_INTENSITY  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_INTENSITY = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_INTENSITY = 3'd5;

    // Channel codes.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic [COORD_FIELD_W-1:0] target_x;
        logic [COORD_FIELD_W-1:0] target_y;
        logic [LUM_W-1:0]         target_luminance;
    } target_t;

    typedef struct packed {
        logic [DUTY_FIELD_W-1:0] duty_red;
        logic [DUTY_FIELD_W-1:0] duty_green;
        logic [DUTY_FIELD_W-1:0] duty_blue;
        logic                    singular;
    } result_t;

    // Multiply and accumulate steps of the solve.
    typedef enum logic [3:0] {
        STEP_MR_A,
        STEP_MR_B,
        STEP_MG_A,
        STEP_MG_B,
        STEP_MB_A,
        STEP_MB_B,
        STEP_S_R,
        STEP_S_G,
        STEP_S_B,
        STEP_CM,
        STEP_NUM,
        STEP_DEN
    } step_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CHECK,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_STORE,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       acc;
        logic       check;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       commit;
        step_t      step;
        logic [1:0] ch;
    } dp_cmd_t;

    typedef struct packed {
        logic singular;
    } dp_status_t;

endpackage

>>> hdl/rlmds_ctrl.sv
module rlmds_ctrl
    import rlmds_pkg::*;
#(
    parameter int DUTY_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam int CNT_W = (DUTY_BITS > 1) ? $clog2(DUTY_BITS) : 1;
    localparam logic [CNT_W-1:0] CntLast = CNT_W'(DUTY_BITS - 1);

    ctl_state_t       state_reg, state_next;
    step_t            step_reg, step_next;
    logic [1:0]       ch_reg, ch_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic             sing_reg, sing_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_MR_A;
            ch_reg    <= CH_RED;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            sing_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ch_reg    <= ch_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            sing_reg  <= sing_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ch_next    = ch_reg;
        cnt_next   = cnt_reg;
        sing_next  = sing_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL;
                    step_next  = STEP_MR_A;
                    ch_next    = CH_RED;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_MUL;
                case (step_reg)
                    STEP_MR_A: step_next = STEP_MR_B;
                    STEP_MR_B: step_next = STEP_MG_A;
                    STEP_MG_A: step_next = STEP_MG_B;
                    STEP_MG_B: step_next = STEP_MB_A;
                    STEP_MB_A: step_next = STEP_MB_B;
                    STEP_MB_B: step_next = STEP_S_R;
                    STEP_S_R:  step_next = STEP_S_G;
                    STEP_S_G:  step_next = STEP_S_B;
                    STEP_S_B:  state_next = ST_CHECK;
                    STEP_CM:   step_next = STEP_NUM;
                    STEP_NUM:  step_next = STEP_DEN;
                    STEP_DEN:  state_next = ST_DIV_INIT;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_CHECK:
            begin
                sing_next = status.singular;
                if (status.singular)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL;
                    step_next  = STEP_CM;
                    ch_next    = CH_RED;
                end
            end
            ST_DIV_INIT:
            begin
                state_next = ST_DIV_STEP;
                cnt_next   = '0;
            end
            ST_DIV_STEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntLast)
                begin
                    state_next = ST_DIV_STORE;
                end
            end
            ST_DIV_STORE:
            begin
                if (ch_reg == CH_BLUE)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL;
                    step_next  = STEP_CM;
                    ch_next    = ch_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd           = '0;
        cmd.step      = step_reg;
        cmd.ch        = ch_reg;
        cmd.load      = (state_reg == ST_IDLE) && start;
        cmd.mul       = (state_reg == ST_MUL);
        cmd.acc       = (state_reg == ST_ACC);
        cmd.check     = (state_reg == ST_CHECK);
        cmd.div_init  = (state_reg == ST_DIV_INIT);
        cmd.div_step  = (state_reg == ST_DIV_STEP);
        cmd.div_store = (state_reg == ST_DIV_STORE);
        cmd.commit    = (state_reg == ST_DONE) && !sing_reg;
        done_next     = (state_reg == ST_DONE);
        busy          = (state_reg != ST_IDLE);
        done          = done_reg;
    end

`ifndef ASSERT_OFF
    // An accepted word always starts the solve.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not start the solve");

    // The result strobe comes as the controller returns to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // One strobe per word.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // The divider only runs for channels of a solvable system.
    a_div_sing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_STEP |-> !sing_reg)
        else $error("divider running on a singular system");
`endif

endmodule

>>> hdl/rlmds_dpath.sv
module rlmds_dpath
    import rlmds_pkg::*;
#(
    parameter int DUTY_BITS  = 16,
    parameter int COORD_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  target_t                target,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output result_t                result
);

    localparam logic [COORD_FIELD_W-1:0] CoordMask =
        COORD_FIELD_W'((32'd1 << COORD_BITS) - 32'd1);
    localparam logic [DUTY_BITS-1:0] DutyFull = {DUTY_BITS{1'b1}};

    // Configuration.
    logic [CFG_DATA_W-1:0]  chroma_reg [3];
    logic [LUM_W-1:0]       inten_reg  [3];

    // Latched target.
    logic [COORD_FIELD_W-1:0] tx_reg, ty_reg;
    logic [LUM_W-1:0]         lum_reg;

    // Arithmetic state.
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [S_W-1:0]    acc_reg;
    logic signed [M_W-1:0]    mr_reg, mg_reg, mb_reg;
    logic signed [S_W-1:0]    s_reg;
    logic [T_W-1:0]           t_reg;
    logic [WIDE_W-1:0]        rem_reg, den_reg;
    logic [DUTY_BITS-1:0]     q_reg;
    logic                     neg_reg, ge_reg;
    logic [DUTY_BITS-1:0]     stage_reg [3];
    logic [DUTY_BITS-1:0]     held_reg  [3];
    logic                     sing_reg;

    logic [COORD_FIELD_W-1:0] cx [3];
    logic [COORD_FIELD_W-1:0] cy [3];
    logic signed [P_W-1:0]    p [3];
    logic signed [P_W-1:0]    q [3];
    logic signed [A_W-1:0]    op_a;
    logic signed [B_W-1:0]    op_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [M_W-1:0]    m_sel;
    logic [M_W-1:0]           m_abs;
    logic [S_W-1:0]           s_abs;
    logic signed [S_W-1:0]    prod_s;
    logic signed [M_W-1:0]    prod_m;
    logic [WIDE_W-1:0]        rem_dbl;
    logic [DUTY_BITS-1:0]     duty_val;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cx[i] = chroma_reg[i][15:0] & CoordMask;
            cy[i] = chroma_reg[i][31:16] & CoordMask;
            p[i]  = $signed({1'b0, tx_reg}) - $signed({1'b0, cx[i]});
            q[i]  = $signed({1'b0, ty_reg}) - $signed({1'b0, cy[i]});
        end
    end

    always_comb
    begin
        case (cmd.ch)
            CH_RED:   m_sel = mr_reg;
            CH_GREEN: m_sel = mg_reg;
            default:  m_sel = mb_reg;
        endcase
        m_abs = m_sel[M_W-1] ? M_W'(-m_sel) : M_W'(m_sel);
        s_abs = s_reg[S_W-1] ? S_W'(-s_reg) : S_W'(s_reg);
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (cmd.step)
            STEP_MR_A: begin op_a = A_W'(p[1]); op_b = B_W'(q[2]); end
            STEP_MR_B: begin op_a = A_W'(p[2]); op_b = B_W'(q[1]); end
            STEP_MG_A: begin op_a = A_W'(p[2]); op_b = B_W'(q[0]); end
            STEP_MG_B: begin op_a = A_W'(p[0]); op_b = B_W'(q[2]); end
            STEP_MB_A: begin op_a = A_W'(p[0]); op_b = B_W'(q[1]); end
            STEP_MB_B: begin op_a = A_W'(p[1]); op_b = B_W'(q[0]); end
            STEP_S_R:
            begin
                op_a = A_W'(mr_reg);
                op_b = $signed(B_W'(cy[0]));
            end
            STEP_S_G:
            begin
                op_a = A_W'(mg_reg);
                op_b = $signed(B_W'(cy[1]));
            end
            STEP_S_B:
            begin
                op_a = A_W'(mb_reg);
                op_b = $signed(B_W'(cy[2]));
            end
            STEP_CM:
            begin
                op_a = $signed(A_W'(m_abs));
                op_b = $signed(B_W'(cy[cmd.ch]));
            end
            STEP_NUM:
            begin
                op_a = $signed(A_W'(t_reg));
                op_b = $signed(B_W'(lum_reg));
            end
            STEP_DEN:
            begin
                op_a = $signed(A_W'(s_abs));
                op_b = $signed(B_W'(inten_reg[cmd.ch]));
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_next = op_a * op_b;
    end

    assign prod_s  = $signed(prod_reg[S_W-1:0]);
    assign prod_m  = $signed(prod_reg[M_W-1:0]);
    assign rem_dbl = {rem_reg[WIDE_W-2:0], 1'b0};

    always_comb
    begin
        if (neg_reg)
            duty_val = '0;
        else if (ge_reg)
            duty_val = DutyFull;
        else
            duty_val = q_reg;
    end

    always_comb
    begin
        status.singular = (cy[0] == '0) || (cy[1] == '0) || (cy[2] == '0) ||
                          (inten_reg[0] == '0) || (inten_reg[1] == '0) ||
                          (inten_reg[2] == '0) || (s_reg == '0);
    end

    // Configuration and held duties carry a reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                chroma_reg[i] <= '0;
                inten_reg[i]  <= '0;
                held_reg[i]   <= '0;
            end
            sing_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RED_CHROMA:      chroma_reg[0] <= cfg_data;
                    CFG_GREEN_CHROMA:    chroma_reg[1] <= cfg_data;
                    CFG_BLUE_CHROMA:     chroma_reg[2] <= cfg_data;
                    CFG_RED_INTENSITY:   inten_reg[0]  <= cfg_data[LUM_W-1:0];
                    CFG_GREEN_INTENSITY: inten_reg[1]  <= cfg_data[LUM_W-1:0];
                    CFG_BLUE_INTENSITY:  inten_reg[2]  <= cfg_data[LUM_W-1:0];
                    default:             ;
                endcase
            end
            if (cmd.check)
            begin
                sing_reg <= status.singular;
            end
            if (cmd.commit)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    held_reg[i] <= stage_reg[i];
                end
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tx_reg  <= target.target_x & CoordMask;
            ty_reg  <= target.target_y & CoordMask;
            lum_reg <= target.target_luminance;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc)
        begin
            case (cmd.step)
                STEP_MR_A, STEP_MG_A, STEP_MB_A: acc_reg <= S_W'(prod_m);
                STEP_MR_B: mr_reg <= M_W'(acc_reg) - prod_m;
                STEP_MG_B: mg_reg <= M_W'(acc_reg) - prod_m;
                STEP_MB_B: mb_reg <= M_W'(acc_reg) - prod_m;
                STEP_S_R:  acc_reg <= prod_s;
                STEP_S_G:  acc_reg <= acc_reg + prod_s;
                STEP_S_B:  s_reg <= acc_reg + prod_s;
                STEP_CM:   t_reg <= prod_reg[T_W-1:0];
                STEP_NUM:  rem_reg <= prod_reg[WIDE_W-1:0];
                STEP_DEN:  den_reg <= prod_reg[WIDE_W-1:0];
                default:   ;
            endcase
        end
        if (cmd.div_init)
        begin
            q_reg   <= '0;
            ge_reg  <= (rem_reg >= den_reg);
            neg_reg <= (m_sel[M_W-1] != s_reg[S_W-1]);
        end
        if (cmd.div_step)
        begin
            if (rem_dbl >= den_reg)
            begin
                rem_reg <= rem_dbl - den_reg;
                q_reg   <= {q_reg[DUTY_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_dbl;
                q_reg   <= {q_reg[DUTY_BITS-2:0], 1'b0};
            end
        end
        if (cmd.div_store)
        begin
            stage_reg[cmd.ch] <= duty_val;
        end
    end

    always_comb
    begin
        result.duty_red   = DUTY_FIELD_W'(held_reg[0]);
        result.duty_green = DUTY_FIELD_W'(held_reg[1]);
        result.duty_blue  = DUTY_FIELD_W'(held_reg[2]);
        result.singular   = sing_reg;
    end

endmodule

>>> hdl/rgb_led_mix_duty_solver_unit.sv
// RGB LED duty solver. Write the chromaticity (x in bits 15:0, y in bits
// 31:16) and full-duty luminance of each LED through the configuration
// channel while the block is idle, then pulse start with a target x, y and
// luminance whenever busy is low. The block solves the three-LED mixing
// system with one shared signed multiplier and a restoring divider, one
// quotient bit per cycle. A solvable word runs the nine cofactor and
// determinant products, each a multiply then an accumulate step, and then
// for each channel three more products and the division before the done
// strobe. A word whose system is singular finishes after the determinant
// check, repeats the previous duties and sets singular. The result is
// valid for the single cycle in which done is high and cannot be held off,
// so the receiver must take it then. The configuration channel is always
// ready; writes to indexes past the blue intensity are ignored.
module rgb_led_mix_duty_solver_unit
    import rlmds_pkg::*;
#(
    parameter int DUTY_BITS  = 16,
    parameter int COORD_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  target_t                target,
    output logic                   done,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration registers are plain flops and take a word every cycle.
    assign cfg_ready = 1'b1;

    rlmds_ctrl #(
        .DUTY_BITS (DUTY_BITS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    rlmds_dpath #(
        .DUTY_BITS  (DUTY_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .target    (target),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule
